>>> rtl/lcd_text_cursor_writer_defines.svh
// assertion macros for the character display text writer
`ifndef LCD_TEXT_CURSOR_WRITER_DEFINES_SVH
`define LCD_TEXT_CURSOR_WRITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LTCW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ltcw assertion failed");

// next-cycle implication, checked out of reset
`define LTCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ltcw assertion failed");

`endif

>>> rtl/ltcw_pkg.sv
// types, constants and helpers for the character display text writer
package ltcw_pkg;

  localparam int unsigned ShadowDepth = 32;
  localparam int unsigned BurstMax    = 4;

  localparam logic       KindChar   = 1'b0;
  localparam logic       KindCursor = 1'b1;
  localparam logic       ByteCmd    = 1'b0;
  localparam logic       ByteData   = 1'b1;

  localparam logic [7:0]  SpaceChar = 8'h20;
  localparam logic [7:0]  CustomHi  = 8'hff;
  localparam logic [15:0] AsciiMax  = 16'h0080;

  typedef struct packed {
    logic        kind;
    logic [15:0] char_code;
    logic [3:0]  set_pos;
    logic [1:0]  set_line;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
  } burst_ent_t;

  // cursor is {line, pos}
  function automatic logic [7:0] word_cmd(input logic [5:0] cursor);
    logic [7:0] base;
    case (cursor[5:4])
      2'd0:    base = 8'h80;
      2'd1:    base = 8'h90;
      2'd2:    base = 8'h88;
      default: base = 8'h98;
    endcase
    return base | {5'b0, cursor[3:1]};
  endfunction

endpackage

>>> rtl/lcd_text_cursor_writer.sv
// the first result of a character item is registered and offered in the cycle after the item is accepted
// results leave one per cycle while the receiver does not stall; a character gives three or four, a cursor set none
// character items are bounded by the single result port draining the burst register;
// a cursor set item leaves no results pending, so it does not hold back the next item
// a new item is taken in the cycle the last result of the previous one is taken
// reset: cursor to line 0 position 0, shadow high bytes to spaces, no pending results
`include "lcd_text_cursor_writer_defines.svh"

module lcd_text_cursor_writer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ltcw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ltcw_pkg::out_item_t out_item_o
);

  logic [5:0] cursor_q, cursor_d;
  logic [7:0] shadow_q [ltcw_pkg::ShadowDepth];
  ltcw_pkg::burst_ent_t ent_q [ltcw_pkg::BurstMax];
  ltcw_pkg::burst_ent_t ent_d [ltcw_pkg::BurstMax];
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q;

  logic       in_fire, out_fire, finishing, busy;
  logic       shw_we;
  logic [4:0] shw_addr;
  logic [7:0] shw_data;
  logic [15:0] glyph;
  logic [5:0] gcur;
  logic [7:0] code_lo;

  assign busy        = (cnt_q != 3'd0);
  assign out_valid_o = busy;
  assign finishing   = ({1'b0, idx_q} + 3'd1 == cnt_q);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign in_stall_o  = busy && !(out_fire && finishing);
  assign in_fire     = in_valid_i && !in_stall_o;

  assign out_item_o.is_data  = ent_q[idx_q].is_data;
  assign out_item_o.bus_byte = ent_q[idx_q].bus_byte;
  assign out_item_o.last     = finishing;

  assign glyph   = (in_item_i.char_code[15:8] == ltcw_pkg::CustomHi) ?
                   ~in_item_i.char_code : in_item_i.char_code;
  assign gcur    = cursor_q + {5'b0, cursor_q[0]};
  assign code_lo = in_item_i.char_code[7:0];

  always_comb begin
    cursor_d = cursor_q;
    cnt_d    = 3'd0;
    shw_we   = 1'b0;
    shw_addr = cursor_q[5:1];
    shw_data = code_lo;
    for (int i = 0; i < ltcw_pkg::BurstMax; i++) begin
      ent_d[i] = '{is_data: ltcw_pkg::ByteData, bus_byte: ltcw_pkg::SpaceChar};
    end
    if (in_item_i.kind == ltcw_pkg::KindCursor) begin
      cursor_d = {in_item_i.set_line, in_item_i.set_pos};
    end else if (in_item_i.char_code > ltcw_pkg::AsciiMax) begin
      shw_we   = 1'b1;
      shw_addr = gcur[5:1];
      shw_data = glyph[15:8];
      cursor_d = cursor_q + (cursor_q[0] ? 6'd3 : 6'd2);
      if (cursor_q[0]) begin
        cnt_d    = 3'd4;
        ent_d[1] = '{is_data: ltcw_pkg::ByteCmd, bus_byte: ltcw_pkg::word_cmd(gcur)};
        ent_d[2] = '{is_data: ltcw_pkg::ByteData, bus_byte: glyph[15:8]};
        ent_d[3] = '{is_data: ltcw_pkg::ByteData, bus_byte: glyph[7:0]};
      end else begin
        cnt_d    = 3'd3;
        ent_d[0] = '{is_data: ltcw_pkg::ByteCmd, bus_byte: ltcw_pkg::word_cmd(gcur)};
        ent_d[1] = '{is_data: ltcw_pkg::ByteData, bus_byte: glyph[15:8]};
        ent_d[2] = '{is_data: ltcw_pkg::ByteData, bus_byte: glyph[7:0]};
      end
    end else begin
      cursor_d = cursor_q + 6'd1;
      ent_d[0] = '{is_data: ltcw_pkg::ByteCmd, bus_byte: ltcw_pkg::word_cmd(cursor_q)};
      if (cursor_q[0]) begin
        cnt_d    = 3'd4;
        ent_d[1] = '{is_data: ltcw_pkg::ByteCmd, bus_byte: ltcw_pkg::word_cmd(cursor_q)};
        ent_d[2] = '{is_data: ltcw_pkg::ByteData, bus_byte: shadow_q[cursor_q[5:1]]};
        ent_d[3] = '{is_data: ltcw_pkg::ByteData, bus_byte: code_lo};
      end else begin
        cnt_d    = 3'd3;
        shw_we   = 1'b1;
        ent_d[1] = '{is_data: ltcw_pkg::ByteData, bus_byte: code_lo};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      for (int i = 0; i < ltcw_pkg::ShadowDepth; i++) begin
        shadow_q[i] <= ltcw_pkg::SpaceChar;
      end
    end else if (in_fire) begin
      cursor_q <= cursor_d;
      cnt_q    <= cnt_d;
      idx_q    <= '0;
      if (shw_we) begin
        shadow_q[shw_addr] <= shw_data;
      end
    end else if (out_fire) begin
      if (finishing) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < ltcw_pkg::BurstMax; i++) begin
        ent_q[i] <= ent_d[i];
      end
    end
  end

  `LTCW_ASSERT_NOW(a_idx_in_burst, out_valid_o, {1'b0, idx_q} < cnt_q)
  `LTCW_ASSERT_NOW(a_last_is_data, out_valid_o && out_item_o.last, out_item_o.is_data)
  `LTCW_ASSERT_NEXT(a_char_gives_burst,
      in_fire && (in_item_i.kind == ltcw_pkg::KindChar),
      out_valid_o && (cnt_q == 3'd3 || cnt_q == 3'd4))
  `LTCW_ASSERT_NEXT(a_cursor_set_silent,
      in_fire && (in_item_i.kind == ltcw_pkg::KindCursor),
      !out_valid_o && (cursor_q == $past({in_item_i.set_line, in_item_i.set_pos})))

endmodule

>>> tb/lcd_text_cursor_writer_checker.sv
// checker for the text writer: tracks cursor and shadow, predicts controller bytes, compares
`timescale 1ns / 100ps

module lcd_text_cursor_writer_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ltcw_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ltcw_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [3:0] cur_pos;
  logic [1:0] cur_line;
  logic [7:0] high_shadow [ltcw_pkg::ShadowDepth];
  ltcw_pkg::out_item_t expected_bytes [$];

  function automatic logic [7:0] addr_cmd(input logic [1:0] line, input logic [3:0] pos);
    logic [7:0] base;
    case (line)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'h90;
      2'd2:    base = 8'h88;
      default: base = 8'h98;
    endcase
    return base | {5'd0, pos[3:1]};
  endfunction

  function automatic ltcw_pkg::out_item_t make_byte(input logic is_data, input logic [7:0] b);
    ltcw_pkg::out_item_t r;
    r.is_data  = is_data;
    r.bus_byte = b;
    r.last     = 1'b0;
    return r;
  endfunction

  task automatic step_cursor();
    cur_pos = cur_pos + 4'd1;
    if (cur_pos == 4'd0) cur_line = cur_line + 2'd1;
  endtask

  task automatic predict_burst(input ltcw_pkg::in_item_t it);
    ltcw_pkg::out_item_t burst [ltcw_pkg::BurstMax];
    int          n;
    logic [15:0] code;
    logic [4:0]  idx;
    n = 0;
    code = it.char_code;
    if (it.kind == ltcw_pkg::KindCursor) begin
      cur_pos  = it.set_pos;
      cur_line = it.set_line;
    end else if (code > ltcw_pkg::AsciiMax) begin
      if (cur_pos[0]) begin
        burst[n] = make_byte(ltcw_pkg::ByteData, ltcw_pkg::SpaceChar);
        n++;
        step_cursor();
      end
      burst[n] = make_byte(ltcw_pkg::ByteCmd, addr_cmd(cur_line, cur_pos));
      n++;
      if (code[15:8] == ltcw_pkg::CustomHi) code = 16'hffff - code;
      high_shadow[{cur_line, cur_pos[3:1]}] = code[15:8];
      burst[n] = make_byte(ltcw_pkg::ByteData, code[15:8]);
      n++;
      step_cursor();
      burst[n] = make_byte(ltcw_pkg::ByteData, code[7:0]);
      n++;
      step_cursor();
    end else begin
      idx = {cur_line, cur_pos[3:1]};
      burst[n] = make_byte(ltcw_pkg::ByteCmd, addr_cmd(cur_line, cur_pos));
      n++;
      if (cur_pos[0]) begin
        burst[n] = make_byte(ltcw_pkg::ByteCmd, addr_cmd(cur_line, cur_pos));
        burst[n+1] = make_byte(ltcw_pkg::ByteData, high_shadow[idx]);
        burst[n+2] = make_byte(ltcw_pkg::ByteData, code[7:0]);
        n += 3;
      end else begin
        high_shadow[idx] = code[7:0];
        burst[n] = make_byte(ltcw_pkg::ByteData, code[7:0]);
        burst[n+1] = make_byte(ltcw_pkg::ByteData, ltcw_pkg::SpaceChar);
        n += 2;
      end
      step_cursor();
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_bytes.push_back(burst[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ltcw_pkg::out_item_t want;
    if (!rst_ni) begin
      cur_pos  = 4'd0;
      cur_line = 2'd0;
      for (int k = 0; k < ltcw_pkg::ShadowDepth; k++) high_shadow[k] = ltcw_pkg::SpaceChar;
      expected_bytes.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected item: is_data %0d bus_byte %02h last %0d",
                 out_item_i.is_data, out_item_i.bus_byte, out_item_i.last);
          fail_count_o++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_item_i.is_data !== want.is_data) begin
            $error("is_data: expected %0d, got %0d", want.is_data, out_item_i.is_data);
            fail_count_o++;
          end
          if (out_item_i.bus_byte !== want.bus_byte) begin
            $error("bus_byte: expected %02h, got %02h", want.bus_byte, out_item_i.bus_byte);
            fail_count_o++;
          end
          if (out_item_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_item_i.last);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_burst(in_item_i);
      pending_o = expected_bytes.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// testbench top for the text writer: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 100ps

module tb_top;

  localparam int HoldCycles   = 80;
  localparam int WatchLimit   = 2000;
  localparam int PhaseItems   = 60;
  localparam int TailCycles   = 10;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  ltcw_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ltcw_pkg::out_item_t out_item;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  logic hold_req = 1'b0;

  int idle_by_phase  [4] = '{0, 56, 0, 23};
  int stall_by_phase [4] = '{0, 0, 56, 23};

  lcd_text_cursor_writer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  lcd_text_cursor_writer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ltcw_pkg::in_item_t char_item(input logic [15:0] code);
    ltcw_pkg::in_item_t it;
    it.kind      = ltcw_pkg::KindChar;
    it.char_code = code;
    it.set_pos   = 4'($urandom);
    it.set_line  = 2'($urandom);
    return it;
  endfunction

  function automatic ltcw_pkg::in_item_t cursor_item(input logic [3:0] pos,
                                                     input logic [1:0] line);
    ltcw_pkg::in_item_t it;
    it.kind      = ltcw_pkg::KindCursor;
    it.char_code = 16'($urandom);
    it.set_pos   = pos;
    it.set_line  = line;
    return it;
  endfunction

  function automatic ltcw_pkg::in_item_t rand_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return cursor_item(4'($urandom), 2'($urandom));
    if (r < 50) return char_item(16'($urandom_range(0, 128)));
    if (r < 62) return char_item({ltcw_pkg::CustomHi, 8'($urandom)});
    if (r < 70) return char_item(16'($urandom));
    return char_item(16'($urandom_range(129, 65535)));
  endfunction

  task automatic send_item(input ltcw_pkg::in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // receiver back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(char_item(16'h0041));
    send_item(char_item(16'h0042));
    send_item(char_item(16'h0000));
    send_item(char_item(ltcw_pkg::AsciiMax));
    send_item(char_item(16'h0081));
    send_item(char_item(16'h007f));
    send_item(char_item(16'hb0a1));
    send_item(cursor_item(4'd9, 2'd0));
    send_item(char_item(16'h0033));
    send_item(char_item(16'hff00));
    send_item(char_item(16'hffff));
    send_item(char_item(16'hff7e));
    send_item(cursor_item(4'd5, 2'd2));
    send_item(char_item(16'h0061));
    send_item(cursor_item(4'd15, 2'd3));
    send_item(char_item(16'h007a));
    send_item(cursor_item(4'd14, 2'd3));
    send_item(char_item(16'hfeff));
    send_item(cursor_item(4'd15, 2'd1));
    send_item(char_item(16'h8000));
    send_item(cursor_item(4'd0, 2'd0));
    send_item(char_item(16'hffff));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      // long receiver hold-off while items keep coming
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < PhaseItems; i++) send_item(rand_item());
      wait_drained();
    end

    stall_pct = 0;
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
